// ----- hw/rtl/mbrhm_pkg.sv -----
// Package for the Modbus RTU read-holding-registers master.
// Holds item structs, codes, the controller state type and the CRC-16 byte update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbrhm_pkg;

    localparam int MAX_REGS_DEF = 20;

    localparam int QTY_W   = 6;
    localparam int CFG_W   = 16;
    localparam int COUNT_W = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDR     = 2'd0;
    localparam logic [1:0] CFG_START_REGISTER = 2'd1;
    localparam logic [1:0] CFG_QUANTITY       = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd3;

    localparam logic [7:0]  SLAVE_ADDR_RST     = 8'd1;
    localparam logic [15:0] START_REGISTER_RST = 16'd1;
    localparam logic [5:0]  QUANTITY_RST       = 6'd2;
    localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd300;

    // input item kinds
    localparam logic [1:0] IN_START = 2'd0;
    localparam logic [1:0] IN_BYTE  = 2'd1;
    localparam logic [1:0] IN_TICK  = 2'd2;

    // result item kinds
    localparam logic [1:0] OUT_TX     = 2'd0;
    localparam logic [1:0] OUT_WORD   = 2'd1;
    localparam logic [1:0] OUT_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_ARG   = 3'd1;
    localparam logic [2:0] STAT_TIMEOUT   = 3'd2;
    localparam logic [2:0] STAT_ADDRESS   = 3'd3;
    localparam logic [2:0] STAT_EXCEPTION = 3'd4;
    localparam logic [2:0] STAT_FUNCTION  = 3'd5;
    localparam logic [2:0] STAT_BYTE_CNT  = 3'd6;
    localparam logic [2:0] STAT_CRC       = 3'd7;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FUNC_EXC_FLAG     = 8'h80;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic [5:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TX,
        S_WAIT,
        S_RD_ADDR,
        S_RD_DATA,
        S_DONE
    } state_t;

    // reflected CRC-16, one byte
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/modbus_rtu_read_holding_master.sv -----
// Modbus RTU master, function 0x03 (read holding registers): request framing,
// response CRC check and register word readout. Uses mbrhm_pkg and mbrhm_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall   | mbrhm_pkg::in_item_t
//  out     | output    | out_valid/out_stall | mbrhm_pkg::out_item_t
//  cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// Received bytes and ticks are taken one per cycle while the output register is free.
// After a start the 8 request bytes leave at one per cycle while the output is free.
// After a good frame each register word is read (S_RD_ADDR), then sent (S_RD_DATA);
// one status item follows. Reset needs no sweep: the word store is only read after
// a full frame wrote it. in_stall is held while the request or the readout is in
// progress, and whenever the output register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_read_holding_master #(
    parameter int MAX_REGS = mbrhm_pkg::MAX_REGS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire mbrhm_pkg::in_item_t        in_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output mbrhm_pkg::out_item_t            out_data,
    input  wire logic                       cfg_write,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [mbrhm_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

    mbrhm_pkg::state_t    state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    mbrhm_pkg::out_item_t out_data_reg, out_data_next;

    logic [7:0]  slave_addr_reg;
    logic [15:0] start_register_reg;
    logic [5:0]  quantity_reg;
    logic [15:0] timeout_ticks_reg;

    logic [7:0]  req_addr_reg, req_addr_next;
    logic [5:0]  req_qty_reg, req_qty_next;
    logic [2:0]  tx_idx_reg, tx_idx_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  rx_count_reg, rx_count_next;
    logic [15:0] wait_ticks_reg, wait_ticks_next;
    logic [5:0]  rd_idx_reg, rd_idx_next;
    logic [7:0]  resp_address_reg, resp_address_next;
    logic [7:0]  resp_function_reg, resp_function_next;
    logic [7:0]  resp_byte_count_reg, resp_byte_count_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [7:0]  high_hold_reg, high_hold_next;

    logic          out_free, in_fire;
    logic          qty_bad;
    logic [7:0]    tx_byte_sel;
    logic [15:0]   ticks_inc;
    logic          timeout_hit;
    logic [7:0]    expected, idx_plus2, body_off;
    logic          is_body, is_crc_lo;
    logic [15:0]   got_crc;
    logic [2:0]    chk_status;
    logic [6:0]    word_pos;
    logic [5:0]    rd_idx_inc;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_wr_addr;
    logic [15:0]   ram_wr_data, ram_rd_data;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == mbrhm_pkg::S_IDLE) || (state_reg == mbrhm_pkg::S_WAIT))
                       || !out_free;
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign qty_bad = (quantity_reg == 6'd0) || (quantity_reg > 6'(MAX_REGS));

    always_comb
    begin
        unique case (tx_idx_reg)
            3'd0: tx_byte_sel = req_addr_reg;
            3'd1: tx_byte_sel = mbrhm_pkg::FUNC_READ_HOLDING;
            3'd2: tx_byte_sel = start_register_reg[15:8];
            3'd3: tx_byte_sel = start_register_reg[7:0];
            3'd4: tx_byte_sel = 8'd0;
            3'd5: tx_byte_sel = {2'b00, req_qty_reg};
            3'd6: tx_byte_sel = crc_reg[7:0];
            3'd7: tx_byte_sel = crc_reg[15:8];
            default: tx_byte_sel = 8'd0;
        endcase
    end

    assign ticks_inc   = (wait_ticks_reg != 16'hFFFF) ? (wait_ticks_reg + 16'd1) : wait_ticks_reg;
    assign timeout_hit = ticks_inc >= timeout_ticks_reg;

    assign expected   = 8'd5 + {1'b0, req_qty_reg, 1'b0};
    assign idx_plus2  = rx_count_reg + 8'd2;
    assign is_body    = idx_plus2 < expected;
    assign is_crc_lo  = idx_plus2 == expected;
    assign body_off   = rx_count_reg - 8'd3;
    assign word_pos   = body_off[7:1];
    assign got_crc    = {in_data.rx_byte, crc_low_reg};
    assign rd_idx_inc = rd_idx_reg + 6'd1;

    always_comb
    begin
        if (resp_address_reg != req_addr_reg)
        begin
            chk_status = mbrhm_pkg::STAT_ADDRESS;
        end
        else if (resp_function_reg == (mbrhm_pkg::FUNC_READ_HOLDING | mbrhm_pkg::FUNC_EXC_FLAG))
        begin
            chk_status = mbrhm_pkg::STAT_EXCEPTION;
        end
        else if (resp_function_reg != mbrhm_pkg::FUNC_READ_HOLDING)
        begin
            chk_status = mbrhm_pkg::STAT_FUNCTION;
        end
        else if (resp_byte_count_reg != {1'b0, req_qty_reg, 1'b0})
        begin
            chk_status = mbrhm_pkg::STAT_BYTE_CNT;
        end
        else if (got_crc != crc_reg)
        begin
            chk_status = mbrhm_pkg::STAT_CRC;
        end
        else
        begin
            chk_status = mbrhm_pkg::STAT_OK;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbrhm_pkg::S_IDLE:
            begin
                if (in_fire && (in_data.kind == mbrhm_pkg::IN_START) && !qty_bad)
                begin
                    state_next = mbrhm_pkg::S_TX;
                end
            end
            mbrhm_pkg::S_WAIT:
            begin
                if (in_fire)
                begin
                    priority if (in_data.kind == mbrhm_pkg::IN_START)
                    begin
                        state_next = qty_bad ? mbrhm_pkg::S_IDLE : mbrhm_pkg::S_TX;
                    end
                    else if (in_data.kind == mbrhm_pkg::IN_TICK)
                    begin
                        if (timeout_hit)
                        begin
                            state_next = mbrhm_pkg::S_IDLE;
                        end
                    end
                    else if (in_data.kind == mbrhm_pkg::IN_BYTE)
                    begin
                        if (!is_body && !is_crc_lo)
                        begin
                            state_next = (chk_status == mbrhm_pkg::STAT_OK) ?
                                         mbrhm_pkg::S_RD_ADDR : mbrhm_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = state_reg;
                    end
                end
            end
            mbrhm_pkg::S_TX:
            begin
                if (out_free && (tx_idx_reg == 3'd7))
                begin
                    state_next = mbrhm_pkg::S_WAIT;
                end
            end
            mbrhm_pkg::S_RD_ADDR:
            begin
                state_next = mbrhm_pkg::S_RD_DATA;
            end
            mbrhm_pkg::S_RD_DATA:
            begin
                if (out_free)
                begin
                    state_next = (rd_idx_inc == req_qty_reg) ? mbrhm_pkg::S_DONE
                                                              : mbrhm_pkg::S_RD_ADDR;
                end
            end
            mbrhm_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = mbrhm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mbrhm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        out_valid_next       = out_valid_reg && out_stall;
        out_data_next        = out_data_reg;
        req_addr_next        = req_addr_reg;
        req_qty_next         = req_qty_reg;
        tx_idx_next          = tx_idx_reg;
        crc_next             = crc_reg;
        rx_count_next        = rx_count_reg;
        wait_ticks_next      = wait_ticks_reg;
        rd_idx_next          = rd_idx_reg;
        resp_address_next    = resp_address_reg;
        resp_function_next   = resp_function_reg;
        resp_byte_count_next = resp_byte_count_reg;
        crc_low_next         = crc_low_reg;
        high_hold_next       = high_hold_reg;
        ram_we               = 1'b0;
        ram_re               = 1'b0;
        ram_wr_addr          = word_pos[AW-1:0];
        ram_wr_data          = {high_hold_reg, in_data.rx_byte};

        unique case (state_reg)
            mbrhm_pkg::S_IDLE, mbrhm_pkg::S_WAIT:
            begin
                if (in_fire && (in_data.kind == mbrhm_pkg::IN_START))
                begin
                    if (qty_bad)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_data_next.out_kind = mbrhm_pkg::OUT_STATUS;
                        out_data_next.status   = mbrhm_pkg::STAT_BAD_ARG;
                        out_data_next.last     = 1'b1;
                    end
                    else
                    begin
                        req_addr_next   = slave_addr_reg;
                        req_qty_next    = quantity_reg;
                        tx_idx_next     = 3'd0;
                        crc_next        = mbrhm_pkg::CRC_INIT;
                        rx_count_next   = 8'd0;
                        wait_ticks_next = 16'd0;
                    end
                end
                else if (in_fire && (state_reg == mbrhm_pkg::S_WAIT)
                         && (in_data.kind == mbrhm_pkg::IN_TICK))
                begin
                    wait_ticks_next = ticks_inc;
                    if (timeout_hit)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '0;
                        out_data_next.out_kind = mbrhm_pkg::OUT_STATUS;
                        out_data_next.status   = mbrhm_pkg::STAT_TIMEOUT;
                        out_data_next.last     = 1'b1;
                    end
                end
                else if (in_fire && (state_reg == mbrhm_pkg::S_WAIT)
                         && (in_data.kind == mbrhm_pkg::IN_BYTE))
                begin
                    rx_count_next = rx_count_reg + 8'd1;
                    priority if (is_body)
                    begin
                        crc_next = mbrhm_pkg::crc16_feed(crc_reg, in_data.rx_byte);
                        priority if (rx_count_reg == 8'd0)
                        begin
                            resp_address_next = in_data.rx_byte;
                        end
                        else if (rx_count_reg == 8'd1)
                        begin
                            resp_function_next = in_data.rx_byte;
                        end
                        else if (rx_count_reg == 8'd2)
                        begin
                            resp_byte_count_next = in_data.rx_byte;
                        end
                        else if (!body_off[0])
                        begin
                            high_hold_next = in_data.rx_byte;
                        end
                        else
                        begin
                            ram_we = 1'b1;
                        end
                    end
                    else if (is_crc_lo)
                    begin
                        crc_low_next = in_data.rx_byte;
                    end
                    else
                    begin
                        rd_idx_next = 6'd0;
                        if (chk_status != mbrhm_pkg::STAT_OK)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_data_next.out_kind = mbrhm_pkg::OUT_STATUS;
                            out_data_next.status   = chk_status;
                            out_data_next.last     = 1'b1;
                            if (chk_status == mbrhm_pkg::STAT_EXCEPTION)
                            begin
                                out_data_next.exception_code = resp_byte_count_reg;
                            end
                        end
                    end
                end
            end
            mbrhm_pkg::S_TX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.out_kind = mbrhm_pkg::OUT_TX;
                    out_data_next.tx_byte  = tx_byte_sel;
                    out_data_next.last     = (tx_idx_reg == 3'd7);
                    tx_idx_next = tx_idx_reg + 3'd1;
                    if (tx_idx_reg < 3'd6)
                    begin
                        crc_next = mbrhm_pkg::crc16_feed(crc_reg, tx_byte_sel);
                    end
                    else if (tx_idx_reg == 3'd7)
                    begin
                        crc_next = mbrhm_pkg::CRC_INIT;  // response CRC starts fresh
                    end
                end
            end
            mbrhm_pkg::S_RD_ADDR:
            begin
                ram_re = 1'b1;
            end
            mbrhm_pkg::S_RD_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.out_kind  = mbrhm_pkg::OUT_WORD;
                    out_data_next.reg_index = rd_idx_reg;
                    out_data_next.reg_value = ram_rd_data;
                    rd_idx_next = rd_idx_inc;
                end
            end
            mbrhm_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.out_kind = mbrhm_pkg::OUT_STATUS;
                    out_data_next.status   = mbrhm_pkg::STAT_OK;
                    out_data_next.last     = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= mbrhm_pkg::S_IDLE;
            out_valid_reg      <= 1'b0;
            tx_idx_reg         <= 3'd0;
            crc_reg            <= mbrhm_pkg::CRC_INIT;
            rx_count_reg       <= 8'd0;
            wait_ticks_reg     <= 16'd0;
            rd_idx_reg         <= 6'd0;
            slave_addr_reg     <= mbrhm_pkg::SLAVE_ADDR_RST;
            start_register_reg <= mbrhm_pkg::START_REGISTER_RST;
            quantity_reg       <= mbrhm_pkg::QUANTITY_RST;
            timeout_ticks_reg  <= mbrhm_pkg::TIMEOUT_TICKS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            tx_idx_reg     <= tx_idx_next;
            crc_reg        <= crc_next;
            rx_count_reg   <= rx_count_next;
            wait_ticks_reg <= wait_ticks_next;
            rd_idx_reg     <= rd_idx_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mbrhm_pkg::CFG_SLAVE_ADDR:     slave_addr_reg     <= cfg_data[7:0];
                    mbrhm_pkg::CFG_START_REGISTER: start_register_reg <= cfg_data;
                    mbrhm_pkg::CFG_QUANTITY:       quantity_reg       <= cfg_data[5:0];
                    mbrhm_pkg::CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                    default:                       slave_addr_reg     <= slave_addr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg        <= out_data_next;
        req_addr_reg        <= req_addr_next;
        req_qty_reg         <= req_qty_next;
        resp_address_reg    <= resp_address_next;
        resp_function_reg   <= resp_function_next;
        resp_byte_count_reg <= resp_byte_count_next;
        crc_low_reg         <= crc_low_next;
        high_hold_reg       <= high_hold_next;
    end

    // words are written only while waiting for the frame and read only after it,
    // so write and read never touch the same entry in one cycle
    mbrhm_ram #(
        .WIDTH (16),
        .DEPTH (MAX_REGS)
    ) u_word_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/mbrhm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mbrhm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mbrhm_chk.sv -----
// Port-level checker for modbus_rtu_read_holding_master, attached by bind.
// Uses mbrhm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrhm_chk (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire mbrhm_pkg::in_item_t         in_data,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire mbrhm_pkg::out_item_t        out_data,
    input wire logic                        cfg_write,
    input wire logic [1:0]                  cfg_index,
    input wire logic [mbrhm_pkg::CFG_W-1:0] cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a start either shows its status at once or blocks input while the request goes out
    a_start_reacts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.kind == mbrhm_pkg::IN_START)
        |=> in_stall || out_valid)
        else $error("start transaction left no trace");

    // no input is taken in the middle of a burst of results
    a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> in_stall)
        else $error("input accepted during result burst");

    // a register word is never directly followed by a request byte
    a_word_then_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (out_data.out_kind == mbrhm_pkg::OUT_WORD)
        |=> !(out_valid && (out_data.out_kind == mbrhm_pkg::OUT_TX)))
        else $error("request byte inside word readout");

endmodule

bind modbus_rtu_read_holding_master mbrhm_chk u_mbrhm_chk (.*);

`default_nettype wire
